// ===== rtl/core/great_circle_distance_assert.svh =====
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH

// property holds in the same cycle
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition implies a property in the next cycle
`define GCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

// ===== rtl/core/gcd_pkg.sv =====
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 31;
  localparam int SQRT_TOP = 60;

  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int NW = 62;

  localparam logic [29:0] CORDIC_GAIN_INV = 30'd652032874;
  localparam logic [30:0] Q30_ONE = 31'h40000000;
  localparam logic [12:0] EARTH_RADIUS_KM = 13'd6378;

  // pi/4 in Q30 over 45 degrees: integer part and the reciprocal of 15 for the rest
  localparam logic [24:0] RAD_INT = 25'd18740330;
  localparam logic [28:0] RECIP15 = 29'd286331154;

  localparam logic [22:0] DIST_CAP =
    23'((64'd4 * 64'd843314856 * 64'd6378 + 64'd2097152) >> 22);

  localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
    30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
  };

endpackage

// ===== rtl/core/gcd_cordic_cell.sv =====
module gcd_cordic_cell #(
  parameter int STEP = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gcd_pkg::XW-1:0]   x_in,
  input  logic signed [gcd_pkg::XW-1:0]   y_in,
  input  logic signed [gcd_pkg::ZW-1:0]   z_in,
  output logic signed [gcd_pkg::XW-1:0]   x_out,
  output logic signed [gcd_pkg::XW-1:0]   y_out,
  output logic signed [gcd_pkg::ZW-1:0]   z_out
);
  import gcd_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] ang;
  logic                 down;

  assign dx  = y_in >>> STEP;
  assign dy  = x_in >>> STEP;
  assign ang = $signed(ZW'(ATAN_TABLE[STEP]));
  // rotation steers on z, vectoring drives y toward zero
  assign down = VECTOR ? (y_in[XW-1] || (y_in == '0)) : !z_in[ZW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (down) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ang;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ang;
      end
    end
  end

endmodule

// ===== rtl/core/gcd_sqrt_cell.sv =====
module gcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [gcd_pkg::NW-1:0] n_in,
  input  logic [gcd_pkg::NW-1:0] r_in,
  output logic [gcd_pkg::NW-1:0] n_out,
  output logic [gcd_pkg::NW-1:0] r_out
);
  import gcd_pkg::*;

  localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (SQRT_TOP - 2 * STEP);

  logic [NW-1:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out <= n_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ===== rtl/core/gcd_angle.sv =====
module gcd_angle #(
  parameter int IN_W = 24,
  parameter int FB = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [IN_W-1:0]        deg,
  output logic signed [gcd_pkg::ZW-1:0] z,
  output logic                          flip
);
  import gcd_pkg::*;

  localparam int AW = FB + 11;
  localparam int MW = FB + 7;
  localparam int PW = MW + 25;
  localparam int QW = MW + 30;
  localparam logic signed [AW-1:0] PERIOD  = AW'(64'd360 << FB);
  localparam logic signed [AW-1:0] HALF    = AW'(64'd180 << FB);
  localparam logic signed [AW-1:0] QUARTER = AW'(64'd90 << FB);

  logic signed [AW-1:0] v;
  logic signed [AW-1:0] r0;
  logic signed [AW-1:0] r1;
  logic                 f1;
  logic [MW-1:0]        m;
  logic                 neg;
  logic                 fl2;
  logic [PW-1:0]        p;
  logic [MW-1:0]        q;
  logic                 neg2;
  logic                 fl3;
  logic [QW-1:0]        qp;
  logic [PW-1:0]        sum;
  logic [ZW-1:0]        zm;

  assign v = AW'(deg);

  // wrap into (-180, 180]
  always_ff @(posedge clk) begin
    if (en) begin
      if (v <= -HALF) begin
        r0 <= v + PERIOD;
      end else if (v > HALF) begin
        r0 <= v - PERIOD;
      end else begin
        r0 <= v;
      end
    end
  end

  // fold into [-90, 90]
  always_comb begin
    r1 = r0;
    f1 = 1'b0;
    if (r0 > QUARTER) begin
      r1 = r0 - HALF;
      f1 = 1'b1;
    end else if (r0 < -QUARTER) begin
      r1 = r0 + HALF;
      f1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m    <= r1[AW-1] ? MW'(-r1) : MW'(r1);
      neg  <= r1[AW-1];
      fl2  <= f1;
    end
  end

  // m * pi/4 / 45 split as m * RAD_INT + floor(2m / 15)
  assign qp = QW'({m, 1'b0}) * QW'(RECIP15);

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= PW'(m) * PW'(RAD_INT);
      q    <= MW'(qp >> 32);
      neg2 <= neg;
      fl3  <= fl2;
    end
  end

  assign sum = p + PW'(q);
  assign zm  = ZW'(sum >> FB);

  always_ff @(posedge clk) begin
    if (en) begin
      z    <= neg2 ? -$signed(zm) : $signed(zm);
      flip <= fl3;
    end
  end

endmodule

// ===== rtl/core/great_circle_distance.sv =====
// Haversine distance between two points given in degrees with 16 fraction bits, result in
// 1/256 km on a 6378 km sphere, saturated at half the circumference. The core is a pipeline
// of rotation cells (30 per angle, four angles side by side), square root cells (31 per root,
// two roots) and 30 vectoring cells for the atan2, with a few multiply stages between them.
// It takes one point pair per clock while the skid entry is empty (s_tready high).
// An output register and one skid entry sit at the result side, so requests keep flowing
// while a result waits; the pipeline halts only while the skid entry is full.
`include "great_circle_distance_assert.svh"

module great_circle_distance (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // src_latitude, src_longitude, dst_latitude, dst_longitude
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata   // distance_out
);
  import gcd_pkg::*;

  localparam int N_IDX  = 5 + CORDIC_STEPS;
  localparam int M3_IDX = N_IDX + 3;
  localparam int PIPE   = M3_IDX + 1 + SQRT_STEPS + CORDIC_STEPS + 2;

  logic                 adv;
  logic                 skid_valid;
  logic [PIPE-1:0]      vld;

  logic signed [23:0]   src_lat;
  logic signed [24:0]   src_lon;
  logic signed [23:0]   dst_lat;
  logic signed [24:0]   dst_lon;
  logic signed [23:0]   lat_s_q;
  logic signed [23:0]   lat_d_q;
  logic signed [24:0]   dlat_q;
  logic signed [25:0]   dlon_q;

  logic signed [ZW-1:0] z0 [4];
  logic [3:0]           flip0;
  logic [3:0]           flip_sr [CORDIC_STEPS];

  logic signed [XW-1:0] rx [4][CORDIC_STEPS+1];
  logic signed [XW-1:0] ry [4][CORDIC_STEPS+1];
  logic signed [ZW-1:0] rz [4][CORDIC_STEPS+1];

  logic signed [XW-1:0]   sdl;
  logic signed [XW-1:0]   sdn;
  logic signed [XW-1:0]   cs1;
  logic signed [XW-1:0]   cs2;
  logic signed [2*XW-1:0] p1;
  logic signed [2*XW-1:0] p2;
  logic signed [2*XW-1:0] p3;
  logic signed [XW-1:0]   u;
  logic signed [XW-1:0]   w;
  logic signed [XW-1:0]   t1;
  logic signed [2*XW-1:0] p4;
  logic signed [XW:0]     a_sum;
  logic [30:0]            a_q;

  logic [NW-1:0] sq_n [2][SQRT_STEPS+1];
  logic [NW-1:0] sq_r [2][SQRT_STEPS+1];

  logic signed [XW-1:0] ax [CORDIC_STEPS+1];
  logic signed [XW-1:0] ay [CORDIC_STEPS+1];
  logic signed [ZW-1:0] az [CORDIC_STEPS+1];

  logic [ZW-1:0] c2;
  logic [45:0]   c_prod;
  logic [23:0]   dsum;
  logic [22:0]   arc_dist;
  logic [22:0]   out_dist;
  logic [22:0]   skid_dist;

  assign adv      = !skid_valid;
  assign s_tready = adv;
  assign m_tdata  = {1'b0, out_dist};

  assign src_lat = s_tdata[23:0];
  assign src_lon = s_tdata[48:24];
  assign dst_lat = s_tdata[72:49];
  assign dst_lon = s_tdata[97:73];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_s_q <= src_lat;
      lat_d_q <= dst_lat;
      dlat_q  <= 25'(dst_lat) - 25'(src_lat);
      dlon_q  <= 26'(dst_lon) - 26'(src_lon);
    end
  end

  gcd_angle #(.IN_W(25), .FB(ANGLE_FRAC_BITS + 1)) u_ang_dlat (
    .clk(clk), .en(adv), .deg(dlat_q), .z(z0[0]), .flip(flip0[0])
  );
  gcd_angle #(.IN_W(26), .FB(ANGLE_FRAC_BITS + 1)) u_ang_dlon (
    .clk(clk), .en(adv), .deg(dlon_q), .z(z0[1]), .flip(flip0[1])
  );
  gcd_angle #(.IN_W(24), .FB(ANGLE_FRAC_BITS)) u_ang_lat_s (
    .clk(clk), .en(adv), .deg(lat_s_q), .z(z0[2]), .flip(flip0[2])
  );
  gcd_angle #(.IN_W(24), .FB(ANGLE_FRAC_BITS)) u_ang_lat_d (
    .clk(clk), .en(adv), .deg(lat_d_q), .z(z0[3]), .flip(flip0[3])
  );

  // sine and cosine rows
  for (genvar r = 0; r < 4; r++) begin : g_rot
    assign rx[r][0] = $signed(XW'(CORDIC_GAIN_INV));
    assign ry[r][0] = '0;
    assign rz[r][0] = z0[r];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      gcd_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_rot (
        .clk(clk), .en(adv),
        .x_in(rx[r][k]), .y_in(ry[r][k]), .z_in(rz[r][k]),
        .x_out(rx[r][k+1]), .y_out(ry[r][k+1]), .z_out(rz[r][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flip_sr[0] <= flip0;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        flip_sr[k] <= flip_sr[k-1];
      end
    end
  end

  // undo the quarter fold, then the products of a
  assign u = XW'(p2 >>> 30);
  assign w = XW'(p3 >>> 30);
  assign a_sum = (XW+1)'(t1) + (XW+1)'(p4 >>> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      sdl <= flip_sr[CORDIC_STEPS-1][0] ? -ry[0][CORDIC_STEPS] : ry[0][CORDIC_STEPS];
      sdn <= flip_sr[CORDIC_STEPS-1][1] ? -ry[1][CORDIC_STEPS] : ry[1][CORDIC_STEPS];
      cs1 <= flip_sr[CORDIC_STEPS-1][2] ? -rx[2][CORDIC_STEPS] : rx[2][CORDIC_STEPS];
      cs2 <= flip_sr[CORDIC_STEPS-1][3] ? -rx[3][CORDIC_STEPS] : rx[3][CORDIC_STEPS];
      p1  <= sdl * sdl;
      p2  <= cs1 * cs2;
      p3  <= sdn * sdn;
      t1  <= XW'(p1 >>> 30);
      p4  <= u * w;
      if (a_sum[XW]) begin
        a_q <= '0;
      end else if (a_sum > (XW+1)'(Q30_ONE)) begin
        a_q <= Q30_ONE;
      end else begin
        a_q <= a_sum[30:0];
      end
    end
  end

  // square roots of a and 1 - a
  assign sq_n[0][0] = NW'({a_q, 30'b0});
  assign sq_n[1][0] = NW'({Q30_ONE - a_q, 30'b0});
  assign sq_r[0][0] = '0;
  assign sq_r[1][0] = '0;

  for (genvar r = 0; r < 2; r++) begin : g_sqrt
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      gcd_sqrt_cell #(.STEP(k)) u_sqrt (
        .clk(clk), .en(adv),
        .n_in(sq_n[r][k]), .r_in(sq_r[r][k]),
        .n_out(sq_n[r][k+1]), .r_out(sq_r[r][k+1])
      );
    end
  end

  // atan2(sqrt(a), sqrt(1 - a))
  assign ax[0] = $signed(XW'(sq_r[1][SQRT_STEPS]));
  assign ay[0] = $signed(XW'(sq_r[0][SQRT_STEPS]));
  assign az[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    gcd_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_vec (
      .clk(clk), .en(adv),
      .x_in(ax[k]), .y_in(ay[k]), .z_in(az[k]),
      .x_out(ax[k+1]), .y_out(ay[k+1]), .z_out(az[k+1])
    );
  end

  // central angle to 1/256 km
  assign c2   = az[CORDIC_STEPS][ZW-1] ? '0 : {az[CORDIC_STEPS][ZW-2:0], 1'b0};
  assign dsum = 24'((c_prod + 46'd2097152) >> 22);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_prod   <= 46'(c2) * 46'(EARTH_RADIUS_KM);
      arc_dist <= (dsum > 24'(DIST_CAP)) ? DIST_CAP : dsum[22:0];
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= vld[PIPE-1];
      end else if (vld[PIPE-1]) begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!m_tvalid || m_tready) begin
        out_dist <= arc_dist;
      end else begin
        skid_dist <= arc_dist;
      end
    end else if (m_tready) begin
      out_dist <= skid_dist;
    end
  end

  `GCD_ASSERT(a_skid_has_out, skid_valid |-> m_tvalid, "skid entry full with output empty")
  `GCD_ASSERT_NEXT(a_stall_hold, skid_valid, $stable(vld), "pipeline moved while stalled")
  `GCD_ASSERT_NEXT(a_skid_empty, m_tready && !skid_valid, !skid_valid, "skid filled on drain")
  `GCD_ASSERT(a_dist_cap, vld[PIPE-1] |-> (arc_dist <= DIST_CAP), "distance above cap")
  `GCD_ASSERT(a_a_range, vld[M3_IDX] |-> (a_q <= Q30_ONE), "haversine term above one")

endmodule
